// ===== rtl/core/mas_pkg.sv =====
// Shared constants, types and helpers for the masked argmax select block.
// Used by every module under rtl/core; depends on nothing else.
package mas_pkg;

    // Sizing of the run and of stored values.
    localparam int MAX_CANDIDATES = 16;
    localparam int VALUE_BITS     = 16;

    // Fixed field widths of the stream items and registers.
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = 4;
    localparam int VALUE_IN_W  = 16;
    localparam int INDEX_W     = 4;
    localparam int CNT_W       = 5;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    // Derived widths for the run position and the stored best position.
    localparam int RUN_W = $clog2(MAX_CANDIDATES + 1);
    localparam int POS_W = $clog2(MAX_CANDIDATES);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_USE_INDEX_MAP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_COUNT = 1'd1;

    // Item kinds carried on tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAND = 1'b1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [RUN_W-1:0]      run_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    // One candidate as seen by the argmax core.
    typedef struct packed {
        logic   valid;
        value_t value;
    } cand_t;

    // One result item.
    typedef struct packed {
        logic               any_valid;
        logic [INDEX_W-1:0] best_index;
    } result_t;

    // Effective run length: zero acts as one, large counts clamp to the maximum.
    function automatic run_t run_length(input logic [CNT_W-1:0] cnt);
        run_t len;
        if (cnt == '0) begin
            len = run_t'(1);
        end else if (int'(cnt) > MAX_CANDIDATES) begin
            len = run_t'(MAX_CANDIDATES);
        end else begin
            len = run_t'(cnt);
        end
        return len;
    endfunction

endpackage

// ===== rtl/core/mas_value_table.sv =====
// Value table of the masked argmax select block: sixteen stored values.
// One write port and one combinational read port; depends on mas_pkg.
module mas_value_table (
    input  logic             aclk,
    input  logic             wr_en,
    input  mas_pkg::addr_t   wr_addr,
    input  mas_pkg::value_t  wr_data,
    input  mas_pkg::addr_t   rd_addr,
    output mas_pkg::value_t  rd_data
);
    import mas_pkg::*;

    // No reset value; the user must load before reading; not enforced.
    value_t entry_reg [TABLE_DEPTH];

    // Load requests write one entry.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    // Candidate lookup in indexed mode.
    assign rd_data = entry_reg[rd_addr];

endmodule

// ===== rtl/core/mas_argmax_core.sv =====
// Running best tracker of the masked argmax select block.
// Holds best value, position, seen flag and run position; depends on mas_pkg.
module mas_argmax_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  mas_pkg::cand_t     cand,
    input  mas_pkg::run_t      run_len,
    output logic               run_last,
    output mas_pkg::result_t   result
);
    import mas_pkg::*;

    value_t best_value_reg, best_value_next;
    pos_t   best_pos_reg,   best_pos_next;
    logic   best_seen_reg,  best_seen_next;
    run_t   run_pos_reg,    run_pos_next;

    logic                take;
    logic [RUN_W:0]      pos_plus_one;

    // A valid candidate wins if no best is held or if strictly greater.
    assign take = cand.valid && (!best_seen_reg || (best_value_reg < cand.value));

    // The run ends once the candidates stepped in reach the current length.
    assign pos_plus_one = {1'b0, run_pos_reg} + (RUN_W + 1)'(1);
    assign run_last     = pos_plus_one >= {1'b0, run_len};

    // Result as it stands after this candidate is folded in.
    always_comb begin
        result.best_index = take ? INDEX_W'(run_pos_reg) : INDEX_W'(best_pos_reg);
        result.any_valid  = take || best_seen_reg;
    end

    // Next state: fold in the candidate, or clear at the end of the run.
    always_comb begin
        best_value_next = best_value_reg;
        best_pos_next   = best_pos_reg;
        best_seen_next  = best_seen_reg;
        run_pos_next    = run_pos_reg;
        if (step) begin
            if (run_last) begin
                best_value_next = '0;
                best_pos_next   = '0;
                best_seen_next  = 1'b0;
                run_pos_next    = '0;
            end else begin
                if (take) begin
                    best_value_next = cand.value;
                    best_pos_next   = POS_W'(run_pos_reg);
                    best_seen_next  = 1'b1;
                end
                run_pos_next = RUN_W'(pos_plus_one);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_value_reg <= '0;
            best_pos_reg   <= '0;
            best_seen_reg  <= 1'b0;
            run_pos_reg    <= '0;
        end else begin
            best_value_reg <= best_value_next;
            best_pos_reg   <= best_pos_next;
            best_seen_reg  <= best_seen_next;
            run_pos_reg    <= run_pos_next;
        end
    end

endmodule

// ===== rtl/core/masked_argmax_select_top.sv =====
// Top level of the masked argmax select block: stream ports, input and result
// registers, configuration registers. Depends on mas_pkg, mas_value_table, mas_argmax_core.
//
// Channel   Direction  Moves
// s_        in         load or candidate request, kind on tuser
// m_        out        one result request at the end of each run
// cfg_      in         register write, no read-back
//
// Requests pass through the input register, one per cycle while no run-ending one stalls.
// A run-ending candidate is written to the result register as it leaves the input register.
// Synchronous reset clears the running best, run position, input and result valid flags.
// A held result stalls only a run-ending candidate; loads and other candidates pass.
// Indexed mode reads an entry loaded by an earlier request, visible on the next one.
module masked_argmax_select_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: entry_addr[3:0], value[19:4], valid_bit[20], map_index[24:21], zero pad
    input  logic [mas_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: opcode[0]
    input  logic                          s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: best_index[3:0], any_valid[4], zero pad
    output logic [mas_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [mas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mas_pkg::CFG_W-1:0]     cfg_wdata
);
    import mas_pkg::*;

    // Configuration registers.
    logic             use_index_map_reg;
    logic [CNT_W-1:0] candidate_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_index_map_reg   <= 1'b0;
            candidate_count_reg <= CNT_W'(16);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_USE_INDEX_MAP:   use_index_map_reg   <= cfg_wdata[0];
                REG_CANDIDATE_COUNT: candidate_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic                  in_valid_reg;
    logic                  in_op_reg;
    addr_t                 in_addr_reg;
    logic [VALUE_IN_W-1:0] in_value_reg;
    logic                  in_cvalid_reg;
    addr_t                 in_midx_reg;

    logic    advance;
    logic    out_free;
    logic    is_cand;
    logic    run_last;
    logic    ends_run;
    value_t  table_rd;
    cand_t   cand;
    result_t result_next;
    result_t result_reg;
    logic    m_valid_reg;

    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg     <= s_tuser;
            in_addr_reg   <= s_tdata[3:0];
            in_value_reg  <= s_tdata[19:4];
            in_cvalid_reg <= s_tdata[20];
            in_midx_reg   <= s_tdata[24:21];
        end
    end

    // The held request moves on unless it ends a run and the result is still held.
    assign is_cand  = in_op_reg == OP_CAND;
    assign ends_run = is_cand && run_last;
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!ends_run || out_free);

    mas_value_table u_table (
        .aclk    (aclk),
        .wr_en   (advance && (in_op_reg == OP_LOAD)),
        .wr_addr (in_addr_reg),
        .wr_data (VALUE_BITS'(in_value_reg)),
        .rd_addr (in_midx_reg),
        .rd_data (table_rd)
    );

    // Candidate value comes from the table in indexed mode.
    always_comb begin
        cand.valid = in_cvalid_reg;
        cand.value = use_index_map_reg ? table_rd : VALUE_BITS'(in_value_reg);
    end

    mas_argmax_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance && is_cand),
        .cand     (cand),
        .run_len  (run_length(candidate_count_reg)),
        .run_last (run_last),
        .result   (result_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && ends_run) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ends_run) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({result_reg.any_valid, result_reg.best_index});

endmodule

// ===== rtl/core/mas_checker.sv =====
// Port-level checks for the masked argmax select block, bound to its top level.
// Depends on mas_pkg and masked_argmax_select_top.
module mas_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mas_pkg::M_TDATA_W-1:0] m_tdata
);
    import mas_pkg::*;

    // A stalled result request stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // Reset empties the result register on the next edge.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A run with no valid candidate reports position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[INDEX_W] |-> m_tdata[INDEX_W-1:0] == '0)
        else $error("nonzero position without a valid candidate");

    // With the result register empty, nothing holds back the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with the result register empty");

endmodule

bind masked_argmax_select_top mas_checker u_mas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
